/* design/cia_pkg.sv */
package cia_pkg;

  localparam int unsigned OperandWidthDefault = 16;
  localparam int unsigned ResultWidth = 33;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

endpackage

/* design/cia_divider.sv */
// Pipelined restoring divider: one quotient bit per stage. The numerator and
// denominator are unsigned magnitudes; the sign is carried alongside and
// applied after the last stage.
module cia_divider import cia_pkg::*; #(
  parameter int unsigned NumWidth = 34,
  parameter int unsigned DenWidth = 33,
  parameter int unsigned TagWidth = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [NumWidth-1:0] num_i,
  input  logic [DenWidth-1:0] den_i,
  input  logic [TagWidth-1:0] tag_i,
  output logic                valid_o,
  output logic [NumWidth-1:0] quot_o,
  output logic [TagWidth-1:0] tag_o
);

  localparam int unsigned RemWidth = DenWidth + 1;

  logic [NumWidth:0]                valid_q;
  logic [NumWidth:0][NumWidth-1:0]  num_q;
  logic [NumWidth:0][RemWidth-1:0]  rem_q;
  logic [NumWidth:0][DenWidth-1:0]  den_q;
  logic [NumWidth:0][TagWidth-1:0]  tag_q;

  assign valid_q[0] = valid_i;
  assign num_q[0]   = num_i;
  assign rem_q[0]   = '0;
  assign den_q[0]   = den_i;
  assign tag_q[0]   = tag_i;

  for (genvar s = 0; s < NumWidth; s++) begin : g_stage
    logic [RemWidth-1:0] shifted_d;
    logic [RemWidth:0]   diff_d;
    logic                valid_n_q;
    logic [NumWidth-1:0] num_n_q;
    logic [RemWidth-1:0] rem_n_q;
    logic [DenWidth-1:0] den_n_q;
    logic [TagWidth-1:0] tag_n_q;

    always_comb begin
      shifted_d = {rem_q[s][RemWidth-2:0], num_q[s][NumWidth-1]};
      diff_d    = {1'b0, shifted_d} - {2'b00, den_q[s]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_n_q <= 1'b0;
      end else begin
        valid_n_q <= valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      num_n_q <= {num_q[s][NumWidth-2:0], ~diff_d[RemWidth]};
      rem_n_q <= diff_d[RemWidth] ? shifted_d : diff_d[RemWidth-1:0];
      den_n_q <= den_q[s];
      tag_n_q <= tag_q[s];
    end

    assign valid_q[s+1] = valid_n_q;
    assign num_q[s+1]   = num_n_q;
    assign rem_q[s+1]   = rem_n_q;
    assign den_q[s+1]   = den_n_q;
    assign tag_q[s+1]   = tag_n_q;
  end

  assign valid_o = valid_q[NumWidth];
  assign quot_o  = num_q[NumWidth];
  assign tag_o   = tag_q[NumWidth];

endmodule

/* design/complex_integer_alu.sv */
// Fully pipelined complex integer ALU. One operation is accepted per cycle
// (busy_o stays low) and every result appears exactly once on the result
// ports, marked by done_o for one cycle. Between the start transfer and done_o
// lie four operand and product stages, one stage per quotient bit of the
// 2*OPERAND_WIDTH + 1 bit divider that every operation flows alongside so
// that results leave in order, and one output register. The receiver cannot
// stall the block.
module complex_integer_alu import cia_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    operation_i,
  input  logic signed [OPERAND_WIDTH-1:0] a_real_i,
  input  logic signed [OPERAND_WIDTH-1:0] a_imag_i,
  input  logic signed [OPERAND_WIDTH-1:0] b_real_i,
  input  logic signed [OPERAND_WIDTH-1:0] b_imag_i,
  output logic                          done_o,
  output logic signed [ResultWidth-1:0] result_real_o,
  output logic signed [ResultWidth-1:0] result_imag_o,
  output logic                          divide_by_zero_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned PW = 2 * W;       // product width
  localparam int unsigned SW = 2 * W + 1;   // sum of two products
  localparam int unsigned MW = 2 * W + 1;   // magnitude of a sum
  localparam int unsigned DW = 2 * W + 1;   // |B|^2

  // Tag carried through the divider: operation, zero flag, sign of the real
  // quotient and the non-divide results.
  typedef struct packed {
    logic [1:0]             op;
    logic                   dz;
    logic                   neg_re;
    logic [ResultWidth-1:0] re;
    logic [ResultWidth-1:0] im;
  } tag_t;

  localparam int unsigned TW = $bits(tag_t);

  assign busy_o = 1'b0;

  // Stage 1: register operands.
  logic          v1_q;
  logic [1:0]    op1_q;
  logic signed [W-1:0] ar1_q, ai1_q, br1_q, bi1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q <= operation_i;
    ar1_q <= a_real_i;
    ai1_q <= a_imag_i;
    br1_q <= b_real_i;
    bi1_q <= b_imag_i;
  end

  // Stage 2: products, and operand sums and differences.
  logic v2_q;
  logic [1:0] op2_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ir_q, p_ri_q, p_bb_r_q, p_bb_i_q;
  logic signed [W:0] add_re_q, add_im_q, sub_re_q, sub_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op2_q    <= op1_q;
    p_rr_q   <= ar1_q * br1_q;
    p_ii_q   <= ai1_q * bi1_q;
    p_ir_q   <= ai1_q * br1_q;
    p_ri_q   <= ar1_q * bi1_q;
    p_bb_r_q <= br1_q * br1_q;
    p_bb_i_q <= bi1_q * bi1_q;
    add_re_q <= (W+1)'($signed(ar1_q)) + (W+1)'($signed(br1_q));
    add_im_q <= (W+1)'($signed(ai1_q)) + (W+1)'($signed(bi1_q));
    sub_re_q <= (W+1)'($signed(ar1_q)) - (W+1)'($signed(br1_q));
    sub_im_q <= (W+1)'($signed(ai1_q)) - (W+1)'($signed(bi1_q));
  end

  // Stage 3: sums of products.
  logic v3_q;
  logic [1:0] op3_q;
  logic signed [SW-1:0] mre_q, mim_q, nre_q, nim_q;
  logic [DW-1:0] den3_q;
  logic signed [W:0] add_re3_q, add_im3_q, sub_re3_q, sub_im3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op3_q     <= op2_q;
    mre_q     <= SW'(p_rr_q) - SW'(p_ii_q);
    mim_q     <= SW'(p_ir_q) + SW'(p_ri_q);
    nre_q     <= SW'(p_rr_q) + SW'(p_ii_q);
    nim_q     <= SW'(p_ir_q) - SW'(p_ri_q);
    den3_q    <= DW'($unsigned(p_bb_r_q)) + DW'($unsigned(p_bb_i_q));
    add_re3_q <= add_re_q;
    add_im3_q <= add_im_q;
    sub_re3_q <= sub_re_q;
    sub_im3_q <= sub_im_q;
  end

  // Stage 4: magnitudes and the divider's tag.
  logic v4_q;
  logic [MW-1:0] mag_re_q, mag_im_q;
  logic [DW-1:0] den4_q;
  logic neg_im4_q;
  tag_t tag4_q, tag4_d;

  always_comb begin
    tag4_d.op     = op3_q;
    tag4_d.dz     = (op3_q == OpDiv) && (den3_q == '0);
    tag4_d.neg_re = nre_q[SW-1];
    case (op_e'(op3_q))
      OpAdd: begin
        tag4_d.re = ResultWidth'(add_re3_q);
        tag4_d.im = ResultWidth'(add_im3_q);
      end
      OpSub: begin
        tag4_d.re = ResultWidth'(sub_re3_q);
        tag4_d.im = ResultWidth'(sub_im3_q);
      end
      default: begin
        tag4_d.re = ResultWidth'(mre_q);
        tag4_d.im = ResultWidth'(mim_q);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag4_q    <= tag4_d;
    neg_im4_q <= nim_q[SW-1];
    mag_re_q  <= nre_q[SW-1] ? MW'(-nre_q) : MW'(nre_q);
    mag_im_q  <= nim_q[SW-1] ? MW'(-nim_q) : MW'(nim_q);
    // A zero divisor is replaced by one; the result is forced to zero later.
    den4_q    <= (den3_q == '0) ? DW'(1) : den3_q;
  end

  // Divider: both quotients share the denominator and run side by side.
  logic            dv_valid;
  logic [MW-1:0]   q_re, q_im;
  logic [TW-1:0]   tag_re_raw;
  logic            neg_im5;
  tag_t            tag5;

  cia_divider #(
    .NumWidth(MW), .DenWidth(DW), .TagWidth(TW)
  ) u_div_re (
    .clk_i, .rst_ni,
    .valid_i(v4_q), .num_i(mag_re_q), .den_i(den4_q), .tag_i(tag4_q),
    .valid_o(dv_valid), .quot_o(q_re), .tag_o(tag_re_raw)
  );

  logic dv_valid_im;

  // The imaginary side carries the sign of its own quotient as its tag.
  cia_divider #(
    .NumWidth(MW), .DenWidth(DW), .TagWidth(1)
  ) u_div_im (
    .clk_i, .rst_ni,
    .valid_i(v4_q), .num_i(mag_im_q), .den_i(den4_q), .tag_i(neg_im4_q),
    .valid_o(dv_valid_im), .quot_o(q_im), .tag_o(neg_im5)
  );

  assign tag5 = tag_t'(tag_re_raw);

  // Final stage: signs and selection.
  logic [ResultWidth-1:0] re_d, im_d;
  logic [ResultWidth-1:0] sq_re, sq_im;

  always_comb begin
    sq_re = ResultWidth'({1'b0, q_re});
    sq_im = ResultWidth'({1'b0, q_im});
    if (tag5.op != OpDiv) begin
      re_d = tag5.re;
      im_d = tag5.im;
    end else if (tag5.dz) begin
      re_d = '0;
      im_d = '0;
    end else begin
      re_d = tag5.neg_re ? -sq_re : sq_re;
      im_d = neg_im5 ? -sq_im : sq_im;
    end
  end

  logic done_q, dz_q;
  logic [ResultWidth-1:0] re_q, im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid & dv_valid_im;
    end
  end

  always_ff @(posedge clk_i) begin
    re_q <= re_d;
    im_q <= im_d;
    dz_q <= tag5.dz;
  end

  assign done_o           = done_q;
  assign result_real_o    = re_q;
  assign result_imag_o    = im_q;
  assign divide_by_zero_o = dz_q;

endmodule

/* design/cia_checker.sv */
module cia_checker import cia_pkg::*; #(
  parameter int unsigned OperandWidth = OperandWidthDefault
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start_i,
  input logic                   busy_o,
  input logic [1:0]             operation_i,
  input logic                   done_o,
  input logic [ResultWidth-1:0] result_real_o,
  input logic [ResultWidth-1:0] result_imag_o,
  input logic                   divide_by_zero_o
);

  localparam int unsigned Latency = 2 * OperandWidth + 6;

  // The block never holds off a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy asserted");

  // A zero-divisor result is always zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && divide_by_zero_o |-> result_real_o == '0 && result_imag_o == '0)
    else $error("zero divisor gave nonzero result");

  // No result appears right after reset without a prior transfer.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !done_o)
    else $error("result right after reset");

  // Every accepted transfer gives its result after the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##Latency done_o)
    else $error("result missing after a transfer");

  // The zero-divisor flag only follows a divide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && divide_by_zero_o |-> $past(operation_i, Latency) == OpDiv)
    else $error("zero-divisor flag without a divide");

endmodule

bind complex_integer_alu cia_checker #(.OperandWidth(OPERAND_WIDTH)) u_cia_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .operation_i, .done_o,
  .result_real_o, .result_imag_o, .divide_by_zero_o
);

/* sim/testbench.sv */
module testbench import cia_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OpW = OperandWidthDefault;
  localparam int unsigned Latency = 2 * OpW + 6;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumRandom = 450;

  typedef struct packed {
    op_e                   op;
    logic signed [OpW-1:0] ar;
    logic signed [OpW-1:0] ai;
    logic signed [OpW-1:0] br;
    logic signed [OpW-1:0] bi;
  } alu_cmd_t;

  typedef struct packed {
    logic [ResultWidth-1:0] re;
    logic [ResultWidth-1:0] im;
    logic                   dbz;
  } alu_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] operation_i = '0;
  logic signed [OpW-1:0] a_real_i = '0, a_imag_i = '0, b_real_i = '0, b_imag_i = '0;
  logic done_o;
  logic signed [ResultWidth-1:0] result_real_o, result_imag_o;
  logic divide_by_zero_o;

  alu_cmd_t cmd_queue[$];
  alu_res_t expected_results[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned div_zero_seen = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  bit hold_for_drain = 1'b0;
  bit stim_done = 1'b0;

  complex_integer_alu u_top (.*);

  always #10 clk_i = ~clk_i;

  // Signed quotient truncated toward zero, wrapped to the result width.
  function automatic logic [ResultWidth-1:0] trunc_div(longint num, longint den);
    longint q;
    q = num / den;
    return q[ResultWidth-1:0];
  endfunction

  function automatic alu_res_t complex_result(alu_cmd_t c);
    alu_res_t r;
    longint ar, ai, br, bi, re, im, den;
    ar = c.ar; ai = c.ai; br = c.br; bi = c.bi;
    re = 0; im = 0;
    r.dbz = 1'b0;
    case (c.op)
      OpAdd: begin re = ar + br; im = ai + bi; end
      OpSub: begin re = ar - br; im = ai - bi; end
      OpMul: begin re = ar * br - ai * bi; im = ai * br + ar * bi; end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.dbz = 1'b1;
        end else begin
          re = ar * br + ai * bi;
          im = ai * br - ar * bi;
          r.re = trunc_div(re, den);
          r.im = trunc_div(im, den);
          return r;
        end
      end
    endcase
    r.re = re[ResultWidth-1:0];
    r.im = im[ResultWidth-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [ResultWidth-1:0] got,
                                 logic [ResultWidth-1:0] want);
    error_count++;
    $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want,
             checked_count);
  endtask

  function automatic logic signed [OpW-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(OpW-1){1'b0}}};
      1: return {1'b0, {(OpW-1){1'b1}}};
      2: return $urandom_range(0, 1) ? OpW'(0) : OpW'(-1);
      3: return OpW'($signed($urandom_range(0, 16)) - 8);
      default: return OpW'($urandom);
    endcase
  endfunction

  task automatic add_cmd(op_e op, int ar, int ai, int br, int bi);
    alu_cmd_t c;
    c.op = op; c.ar = OpW'(ar); c.ai = OpW'(ai); c.br = OpW'(br); c.bi = OpW'(bi);
    cmd_queue = {cmd_queue, c};
  endtask

  task automatic c_drive(alu_cmd_t c);
    start_i <= 1'b1;
    operation_i <= c.op;
    a_real_i <= c.ar;
    a_imag_i <= c.ai;
    b_real_i <= c.br;
    b_imag_i <= c.bi;
  endtask

  initial begin
    alu_cmd_t c;
    for (int op = 0; op < 4; op++) begin
      add_cmd(op_e'(op), 32767, 32767, 32767, 32767);
      add_cmd(op_e'(op), -32768, -32768, -32768, -32768);
      add_cmd(op_e'(op), -32768, 32767, 32767, -32768);
      add_cmd(op_e'(op), 0, 0, 0, 0);
      add_cmd(op_e'(op), 7, -7, 2, 3);
    end
    // Divide by zero with a nonzero numerator, and truncation of negative quotients.
    add_cmd(OpDiv, 1234, -999, 0, 0);
    add_cmd(OpDiv, -7, 0, 2, 0);
    add_cmd(OpDiv, 1, 1, 32767, -32768);
    add_cmd(OpDiv, -32768, -32768, -1, 0);
    for (int i = 0; i < NumRandom; i++) begin
      c.op = op_e'($urandom_range(0, 3));
      c.ar = rand_operand();
      c.ai = rand_operand();
      c.br = rand_operand();
      c.bi = rand_operand();
      if (c.op == OpDiv && $urandom_range(0, 15) == 0) begin
        c.br = '0;
        c.bi = '0;
      end
      cmd_queue = {cmd_queue, c};
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: bursts of transfers separated by random gaps, with one full drain midway.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        sent_count++;
        if (sent_count == 200) hold_for_drain = 1'b1;
      end
      if (hold_for_drain && expected_results.size() == 0 && !(start_i && !busy_o)) begin
        hold_for_drain = 1'b0;
      end
      if (!(start_i && busy_o)) begin
        if (burst_left == 0 && gap_left > 0) begin
          gap_left--;
        end else if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        end
        if (cmd_queue.size() > 0 && !hold_for_drain && burst_left > 0) begin
          c_drive(cmd_queue.pop_front());
          burst_left--;
        end else begin
          start_i <= 1'b0;
          operation_i <= 2'($urandom);
          a_real_i <= OpW'($urandom);
          if (cmd_queue.size() == 0) stim_done = 1'b1;
        end
      end
    end
  end

  // Monitor: record each accepted transfer and check each strobed result.
  always @(posedge clk_i) begin
    alu_cmd_t c;
    alu_res_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", result_real_o, '0);
        end else begin
          want = expected_results.pop_front();
          if (result_real_o !== want.re) report_mismatch("result_real", result_real_o, want.re);
          if (result_imag_o !== want.im) report_mismatch("result_imag", result_imag_o, want.im);
          if (divide_by_zero_o !== want.dbz)
            report_mismatch("divide_by_zero", ResultWidth'(divide_by_zero_o),
                            ResultWidth'(want.dbz));
          if (want.dbz) div_zero_seen++;
          checked_count++;
        end
      end
      if (start_i && !busy_o) begin
        c.op = op_e'(operation_i);
        c.ar = a_real_i; c.ai = a_imag_i; c.br = b_real_i; c.bi = b_imag_i;
        expected_results = {expected_results, complex_result(c)};
      end
    end
  end

  initial begin
    wait (stim_done && expected_results.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (expected_results.size() != 0) error_count++;
    $display("Checked %0d results of four operations, %0d of them division by zero.",
             checked_count, div_zero_seen);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

/* sim.f */
design/cia_pkg.sv
design/cia_divider.sv
design/complex_integer_alu.sv
design/cia_checker.sv
sim/testbench.sv
